>>> design/slxc_pkg.sv
// Shared types, constants, matrices and curve-table builders for the sRGB/XYZ converter.
`timescale 1ns / 1ps

package slxc_pkg;

    // Channel fraction bits by default
    localparam int FRAC_BITS_DEF = 16;

    // Internal Q30 word
    localparam int VAL_W    = 38;
    localparam int IQ       = 30;

    // Curve tables: 14 octaves of 128 segments
    localparam int SEG_BITS   = 7;
    localparam int SEG_N      = 1 << SEG_BITS;
    localparam int SEG_MASK   = SEG_N - 1;
    localparam int OCTAVES    = 14;
    localparam int TAB_LEN    = (OCTAVES << SEG_BITS) + 1;
    localparam int IDX_W      = $clog2(TAB_LEN);
    localparam int OCT_W      = $clog2(OCTAVES);
    localparam int LOW_MSB    = 21;
    localparam int LIN_W      = 35;
    localparam int SH_W       = 5;
    localparam int T_W        = LIN_W - SEG_BITS - 1;
    localparam int TAB_SHIFT0 = IQ - 9 - SEG_BITS;
    localparam int LOG_FRAC   = 28;
    localparam int DIFF_W     = 32;

    // Transfer constants (Q30)
    localparam logic [63:0] TH_DEC     = 64'd43432857;
    localparam logic [63:0] TH_ENC     = 64'd3361671;
    localparam logic [63:0] C_OFF      = 64'd59055800;
    localparam logic [63:0] C_GAIN     = 64'd1132797624;
    localparam logic [63:0] C_SLOPE    = 64'd13872744366;
    localparam logic [63:0] C_INVSLOPE = 64'd83106952;

    // Matrix coefficients, Q24
    localparam int COEF_W = 27;
    localparam int MAT_SH = 24;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef val_t                     rom_t [TAB_LEN];
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t                    mat_t [3][3];
    typedef logic [63:0]              roots_t [LOG_FRAC+1];

    localparam mat_t FWD_MAT = '{
        '{27'sd6918924,  27'sd5999532,  27'sd3028287},
        '{27'sd3566836,  27'sd11999065, 27'sd1211315},
        '{27'sd323800,   27'sd1999844,  27'sd15946744}};

    localparam mat_t INV_MAT = '{
        '{27'sd54368246,  -27'sd25789936, -27'sd8365120},
        '{-27'sd16255445, 27'sd31470702,  27'sd696254},
        '{27'sd934491,    -27'sd3422552,  27'sd17733517}};

    // Conversion modes; codes six and seven pass the pixel through
    typedef enum logic [2:0] {
        MODE_SRGB2LIN = 3'd0,
        MODE_LIN2SRGB = 3'd1,
        MODE_LIN2XYZ  = 3'd2,
        MODE_XYZ2LIN  = 3'd3,
        MODE_SRGB2XYZ = 3'd4,
        MODE_XYZ2SRGB = 3'd5
    } mode_t;

    // Per-item unit enables
    typedef struct packed {
        logic dec_on;
        logic fwd;
        logic inv;
        logic enc_on;
    } ctl_t;

    // Position of the highest set bit, -1 for zero
    function automatic int msb64(input logic [63:0] v);
        int p;
        p = -1;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = i;
        end
        return p;
    endfunction

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] vin);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = vin;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Floor division by twelve and by five
    function automatic longint fdiv12(input longint a);
        longint q;
        q = a / 12;
        if ((a % 12) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint fdiv5(input longint a);
        longint q;
        q = a / 5;
        if ((a % 5) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    // log2 of a positive Q30 value, Q28 result, by repeated squaring
    function automatic longint log2q(input logic [63:0] vin);
        logic [63:0] v;
        logic [63:0] m;
        int          p;
        longint      frac;
        v = (vin == 64'd0) ? 64'd1 : vin;
        p = msb64(v);
        if (p >= IQ) m = v >> (p - IQ);
        else         m = v << (IQ - p);
        frac = 0;
        for (int i = 0; i < LOG_FRAC; i++) begin
            m    = (m * m + (64'd1 << 29)) >> IQ;
            frac = frac <<< 1;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | 64'sd1;
            end
        end
        return longint'(p - IQ) * (longint'(1) <<< LOG_FRAC) + frac;
    endfunction

    // 2 to a Q28 power, Q30 result, from the chain of square roots
    function automatic longint exp2q(input longint l, input roots_t rt);
        longint      n;
        longint      f;
        logic [63:0] r;
        n = l >>> LOG_FRAC;
        f = l & ((longint'(1) <<< LOG_FRAC) - 1);
        r = 64'd1 << IQ;
        for (int j = 1; j <= LOG_FRAC; j++) begin
            if (f[LOG_FRAC-j]) r = (r * rt[j] + (64'd1 << 29)) >> IQ;
        end
        if (n >= 0) begin
            if (n > 24) n = 24;
            return longint'(r << n);
        end
        if (-n >= 40) return 0;
        return longint'((r + (64'd1 << (-n - 1))) >> (-n));
    endfunction

    // Sample table for the decode or the encode power curve
    function automatic rom_t build_rom(input logic is_enc);
        rom_t        tab;
        roots_t      rt;
        longint      lg_gain;
        longint      ld;
        longint      le;
        logic [63:0] x;
        int          oct;
        int          k;
        rt[0] = 64'd1 << 31;
        rt[1] = isqrt64(64'd1 << 61);
        for (int j = 2; j <= LOG_FRAC; j++) begin
            rt[j] = isqrt64(rt[j-1] << IQ);
        end
        lg_gain = log2q(C_GAIN);
        for (int i = 0; i < TAB_LEN; i++) begin
            oct = i >> SEG_BITS;
            k   = i & SEG_MASK;
            x   = 64'(SEG_N + k) << (TAB_SHIFT0 + oct);
            if (is_enc) begin
                le     = fdiv12(log2q(x) * 5) + lg_gain;
                tab[i] = VAL_W'(exp2q(le, rt) - longint'(C_OFF));
            end else begin
                ld     = log2q(x + C_OFF) - lg_gain;
                tab[i] = VAL_W'(exp2q(fdiv5(ld * 12), rt));
            end
        end
        return tab;
    endfunction

endpackage

>>> design/slxc_xfer.sv
// sRGB transfer curve unit, decode or encode, seven register stages.
`timescale 1ns / 1ps

module slxc_xfer #(
    parameter bit IS_ENC = 1'b0
) (
    input  logic                 aclk,
    input  logic [6:0]           ld,
    input  logic                 en_in,
    input  slxc_pkg::val_t       x_in,
    output slxc_pkg::val_t       y_out
);

    localparam int VAL_W  = slxc_pkg::VAL_W;
    localparam int LIN_W  = slxc_pkg::LIN_W;
    localparam int SEGB   = slxc_pkg::SEG_BITS;
    localparam int OCT_W  = slxc_pkg::OCT_W;
    localparam int SH_W   = slxc_pkg::SH_W;
    localparam int T_W    = slxc_pkg::T_W;
    localparam int IDX_W  = slxc_pkg::IDX_W;
    localparam int DIFF_W = slxc_pkg::DIFF_W;
    localparam int IQ     = slxc_pkg::IQ;
    localparam int P_W    = DIFF_W + T_W;
    localparam int SH0    = slxc_pkg::LOW_MSB - SEGB;

    // Linear segment: x below threshold times slope, Q30
    localparam int LIN_XW = IS_ENC ? 22 : 26;
    localparam int LIN_CW = IS_ENC ? 34 : 27;
    localparam int LIN_PW = LIN_XW + LIN_CW;
    localparam logic [LIN_CW-1:0] LIN_C =
        LIN_CW'(IS_ENC ? slxc_pkg::C_SLOPE : slxc_pkg::C_INVSLOPE);
    localparam logic [LIN_W-1:0] TH =
        LIN_W'(IS_ENC ? slxc_pkg::TH_ENC : slxc_pkg::TH_DEC);

    localparam slxc_pkg::rom_t ROM = slxc_pkg::build_rom(IS_ENC);

    // Stage registers
    slxc_pkg::val_t          x1_reg, x2_reg, x3_reg, x4_reg, x5_reg, x6_reg;
    logic                    en1_reg, en2_reg, en3_reg, en4_reg, en5_reg, en6_reg;
    logic [LIN_W-1:0]        xc1_reg, xc2_reg;
    logic [LIN_W-1:0]        xc1_next;
    logic                    lin2_reg, lin3_reg, lin4_reg, lin5_reg, lin6_reg;
    logic [OCT_W-1:0]        oct2_reg, oct2_next;
    logic [IDX_W-1:0]        idx3_reg, idx3_next, idx_nx;
    logic [T_W-1:0]          t3_reg, t4_reg, t5_reg, t3_next;
    logic [SH_W-1:0]         sh3_reg, sh4_reg, sh5_reg, sh6_reg, sh3_next;
    logic [LIN_PW-1:0]       lp3_reg;
    slxc_pkg::val_t          ly4_reg, ly5_reg, ly6_reg;
    slxc_pkg::val_t          base4_reg, next4_reg, base5_reg, base6_reg;
    logic                    neg5_reg, neg6_reg;
    logic [DIFF_W-1:0]       mag5_reg;
    logic [P_W-1:0]          prod6_reg;
    slxc_pkg::val_t          y7_reg, y7_next;
    logic signed [VAL_W:0]   diff;
    logic [LIN_W-1:0]        shifted;
    logic [LIN_W-1:0]        tmask;
    logic [P_W-1:0]          adj;

    // Clamp to [0, 2^35-1]
    always_comb begin
        if (x_in[VAL_W-1])              xc1_next = '0;
        else if (|x_in[VAL_W-2:LIN_W])  xc1_next = '1;
        else                            xc1_next = x_in[LIN_W-1:0];
    end

    // Octave of the top set bit, bits 21 to 34
    always_comb begin
        oct2_next = '0;
        for (int i = 0; i < slxc_pkg::OCTAVES; i++) begin
            if (xc1_reg[slxc_pkg::LOW_MSB+i]) oct2_next = OCT_W'(i);
        end
    end

    // Table index and offset within the segment
    always_comb begin
        sh3_next  = SH_W'(oct2_reg) + SH_W'(SH0);
        shifted   = xc2_reg >> sh3_next;
        idx3_next = {oct2_reg, shifted[SEGB-1:0]};
        tmask     = (LIN_W'(1) << sh3_next) - LIN_W'(1);
        t3_next   = T_W'(xc2_reg & tmask);
    end

    assign idx_nx = idx3_reg + IDX_W'(1);
    assign diff   = (VAL_W+1)'(next4_reg) - (VAL_W+1)'(base4_reg);

    // Interpolation and output select
    always_comb begin
        adj = (prod6_reg + (P_W'(1) << (sh6_reg - SH_W'(1)))) >> sh6_reg;
        if (!en6_reg)      y7_next = x6_reg;
        else if (lin6_reg) y7_next = ly6_reg;
        else if (neg6_reg) y7_next = base6_reg - VAL_W'(adj);
        else               y7_next = base6_reg + VAL_W'(adj);
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            x1_reg  <= x_in;
            en1_reg <= en_in;
            xc1_reg <= xc1_next;
        end
        if (ld[1]) begin
            x2_reg   <= x1_reg;
            en2_reg  <= en1_reg;
            xc2_reg  <= xc1_reg;
            lin2_reg <= (xc1_reg < TH);
            oct2_reg <= oct2_next;
        end
        if (ld[2]) begin
            x3_reg   <= x2_reg;
            en3_reg  <= en2_reg;
            lin3_reg <= lin2_reg;
            idx3_reg <= idx3_next;
            t3_reg   <= t3_next;
            sh3_reg  <= sh3_next;
            lp3_reg  <= LIN_PW'(xc2_reg[LIN_XW-1:0]) * LIN_PW'(LIN_C);
        end
        // Table read at both ends of the segment
        if (ld[3]) begin
            x4_reg    <= x3_reg;
            en4_reg   <= en3_reg;
            lin4_reg  <= lin3_reg;
            t4_reg    <= t3_reg;
            sh4_reg   <= sh3_reg;
            ly4_reg   <= VAL_W'((lp3_reg + (LIN_PW'(1) << (IQ - 1))) >> IQ);
            base4_reg <= ROM[idx3_reg];
            next4_reg <= ROM[idx_nx];
        end
        if (ld[4]) begin
            x5_reg    <= x4_reg;
            en5_reg   <= en4_reg;
            lin5_reg  <= lin4_reg;
            t5_reg    <= t4_reg;
            sh5_reg   <= sh4_reg;
            ly5_reg   <= ly4_reg;
            base5_reg <= base4_reg;
            neg5_reg  <= diff[VAL_W];
            mag5_reg  <= diff[VAL_W] ? DIFF_W'(-diff) : DIFF_W'(diff);
        end
        if (ld[5]) begin
            x6_reg    <= x5_reg;
            en6_reg   <= en5_reg;
            lin6_reg  <= lin5_reg;
            sh6_reg   <= sh5_reg;
            ly6_reg   <= ly5_reg;
            base6_reg <= base5_reg;
            neg6_reg  <= neg5_reg;
            prod6_reg <= P_W'(mag5_reg) * P_W'(t5_reg);
        end
        if (ld[6]) begin
            y7_reg <= y7_next;
        end
    end

    assign y_out = y7_reg;

endmodule

>>> design/srgb_linear_xyz_convert.sv
// Top level of the sRGB / linear / XYZ pixel converter.
`timescale 1ns / 1ps
//
//  channel   handshake               payload
//  --------  ----------------------  ---------------------------------------
//  input     s_valid / s_ready       s_chan0_in, s_chan1_in, s_chan2_in
//  result    m_valid / m_ready       m_chan0_out .. m_chan2_out, m_saturated
//  config    cfg_valid / cfg_ready   cfg_data (conversion mode)
//
//  One item per clock while the result side keeps taking items; stages: input register,
//  decode curve (7), matrix (4), encode curve (7), round and clip (1). The curve
//  tables are registered ROM reads, one stage each. Reset clears the valid bits
//  and the mode; no clearing pass. A stage takes a new item whenever it is empty
//  or the one after it moves, so a stalled result does not block bubbles.

module srgb_linear_xyz_convert #(
    parameter int FRAC_BITS = slxc_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [FRAC_BITS+2:0] s_chan0_in,
    input  logic signed [FRAC_BITS+2:0] s_chan1_in,
    input  logic signed [FRAC_BITS+2:0] s_chan2_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [FRAC_BITS+2:0] m_chan0_out,
    output logic signed [FRAC_BITS+2:0] m_chan1_out,
    output logic signed [FRAC_BITS+2:0] m_chan2_out,
    output logic                        m_saturated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_data
);

    localparam int CH_W   = FRAC_BITS + 3;
    localparam int VAL_W  = slxc_pkg::VAL_W;
    localparam int SH     = slxc_pkg::IQ - FRAC_BITS;
    localparam int NST    = 20;
    localparam int S_DEC  = 1;
    localparam int S_MAT  = 8;
    localparam int S_ENC  = 12;
    localparam int S_OUT  = NST - 1;
    localparam int VL_W   = 18;
    localparam int VH_W   = VAL_W - VL_W;
    localparam int PH_W   = slxc_pkg::COEF_W + VH_W;
    localparam int PL_W   = slxc_pkg::COEF_W + VL_W + 1;
    localparam int HS_W   = PH_W + 2;
    localparam int LS_W   = PL_W + 2;
    localparam int SUM_W  = HS_W + VL_W + 1;
    localparam int MSH    = slxc_pkg::MAT_SH;
    localparam slxc_pkg::val_t CH_MAX = VAL_W'((longint'(1) <<< (CH_W - 1)) - 1);
    localparam slxc_pkg::val_t CH_MIN = -CH_MAX - VAL_W'(1);

    logic [2:0]          mode_reg;
    logic [NST-1:0]      v_reg;
    logic [NST-1:0]      ld;
    slxc_pkg::ctl_t      ctl_reg [NST];
    slxc_pkg::ctl_t      ctl_next;

    slxc_pkg::val_t      x0_reg [3];
    slxc_pkg::val_t      d_y [3];
    slxc_pkg::val_t      e_y [3];

    logic signed [PH_W-1:0]  ph_reg [3][3];
    logic signed [PL_W-1:0]  pl_reg [3][3];
    logic signed [PH_W-1:0]  ph_next [3][3];
    logic signed [PL_W-1:0]  pl_next [3][3];
    logic signed [HS_W-1:0]  hs_reg [3];
    logic signed [LS_W-1:0]  ls_reg [3];
    logic signed [SUM_W-1:0] tot_reg [3];
    logic signed [SUM_W-1:0] rnd [3];
    slxc_pkg::val_t          byp1_reg [3], byp2_reg [3], byp3_reg [3];
    slxc_pkg::val_t          m_y_reg [3];
    slxc_pkg::val_t          q [3];
    logic signed [CH_W-1:0]  out_reg [3];
    logic signed [CH_W-1:0]  out_next [3];
    logic                    sat_reg, sat_next;
    slxc_pkg::coef_t         coef [3][3];

    // Mode register; writes should land only while idle: the user keeps to this, the block leaves it unenforced
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= slxc_pkg::MODE_SRGB2LIN;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // Stage load enables: a stage loads when empty or when the next one loads
    assign ld[S_OUT] = !v_reg[S_OUT] || m_ready;
    genvar gk;
    generate
        for (gk = 0; gk < NST - 1; gk++) begin : g_ld
            assign ld[gk] = !v_reg[gk] || ld[gk+1];
        end
    endgenerate
    assign s_ready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) v_reg[0] <= s_valid;
            for (int k = 1; k < NST; k++) begin
                if (ld[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Unit enables from the mode
    always_comb begin
        ctl_next = '0;
        case (mode_reg)
            slxc_pkg::MODE_SRGB2LIN: ctl_next.dec_on = 1'b1;
            slxc_pkg::MODE_LIN2SRGB: ctl_next.enc_on = 1'b1;
            slxc_pkg::MODE_LIN2XYZ:  ctl_next.fwd    = 1'b1;
            slxc_pkg::MODE_XYZ2LIN:  ctl_next.inv    = 1'b1;
            slxc_pkg::MODE_SRGB2XYZ: begin
                ctl_next.dec_on = 1'b1;
                ctl_next.fwd    = 1'b1;
            end
            slxc_pkg::MODE_XYZ2SRGB: begin
                ctl_next.inv    = 1'b1;
                ctl_next.enc_on = 1'b1;
            end
            default: ctl_next = '0;
        endcase
    end

    // Input stage: scale to Q30
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            ctl_reg[0] <= ctl_next;
            x0_reg[0]  <= VAL_W'(s_chan0_in) <<< SH;
            x0_reg[1]  <= VAL_W'(s_chan1_in) <<< SH;
            x0_reg[2]  <= VAL_W'(s_chan2_in) <<< SH;
        end
        for (int k = 1; k < NST; k++) begin
            if (ld[k]) ctl_reg[k] <= ctl_reg[k-1];
        end
    end

    // Curve units per channel
    genvar gc;
    generate
        for (gc = 0; gc < 3; gc++) begin : g_ch
            slxc_xfer #(.IS_ENC(1'b0)) u_dec (
                .aclk  (aclk),
                .ld    (ld[S_DEC+6:S_DEC]),
                .en_in (ctl_reg[S_DEC-1].dec_on),
                .x_in  (x0_reg[gc]),
                .y_out (d_y[gc])
            );
            slxc_xfer #(.IS_ENC(1'b1)) u_enc (
                .aclk  (aclk),
                .ld    (ld[S_ENC+6:S_ENC]),
                .en_in (ctl_reg[S_ENC-1].enc_on),
                .x_in  (m_y_reg[gc]),
                .y_out (e_y[gc])
            );
        end
    endgenerate

    // Matrix partial products: value split into a signed high and unsigned low part
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r][c] = ctl_reg[S_MAT-1].inv ? slxc_pkg::INV_MAT[r][c]
                                                  : slxc_pkg::FWD_MAT[r][c];
                ph_next[r][c] = PH_W'(coef[r][c]) *
                                PH_W'($signed(d_y[c][VAL_W-1:VL_W]));
                pl_next[r][c] = PL_W'(coef[r][c]) *
                                PL_W'($signed({1'b0, d_y[c][VL_W-1:0]}));
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rnd[r] = (tot_reg[r] + (SUM_W'(1) <<< (MSH - 1))
                     - SUM_W'(tot_reg[r][SUM_W-1])) >>> MSH;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[S_MAT]) begin
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            byp1_reg <= d_y;
        end
        if (ld[S_MAT+1]) begin
            for (int r = 0; r < 3; r++) begin
                hs_reg[r] <= HS_W'(ph_reg[r][0]) + HS_W'(ph_reg[r][1]) + HS_W'(ph_reg[r][2]);
                ls_reg[r] <= LS_W'(pl_reg[r][0]) + LS_W'(pl_reg[r][1]) + LS_W'(pl_reg[r][2]);
            end
            byp2_reg <= byp1_reg;
        end
        if (ld[S_MAT+2]) begin
            for (int r = 0; r < 3; r++) begin
                tot_reg[r] <= (SUM_W'(hs_reg[r]) <<< VL_W) + SUM_W'(ls_reg[r]);
            end
            byp3_reg <= byp2_reg;
        end
        // Round half away from zero, or pass through
        if (ld[S_MAT+3]) begin
            for (int r = 0; r < 3; r++) begin
                if (ctl_reg[S_MAT+2].fwd || ctl_reg[S_MAT+2].inv) begin
                    m_y_reg[r] <= VAL_W'(rnd[r]);
                end else begin
                    m_y_reg[r] <= byp3_reg[r];
                end
            end
        end
    end

    // Final rounding to the channel format and clipping
    always_comb begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            q[i] = $signed(e_y[i] + (VAL_W'(1) <<< (SH - 1))
                   - VAL_W'(e_y[i][VAL_W-1])) >>> SH;
            if (q[i] > CH_MAX) begin
                out_next[i] = CH_W'(CH_MAX);
                sat_next    = 1'b1;
            end else if (q[i] < CH_MIN) begin
                out_next[i] = CH_W'(CH_MIN);
                sat_next    = 1'b1;
            end else begin
                out_next[i] = CH_W'(q[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[S_OUT]) begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    assign m_valid     = v_reg[S_OUT];
    assign m_chan0_out = out_reg[0];
    assign m_chan1_out = out_reg[1];
    assign m_chan2_out = out_reg[2];
    assign m_saturated = sat_reg;

`ifndef SYNTHESIS
    // Empty output stage always opens the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[S_OUT] |-> s_ready)
        else $error("input blocked with empty output stage");

    // Full pipeline under a stall accepts nothing
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg && !m_ready) |-> !s_ready)
        else $error("item taken into a full stalled pipeline");

    // A mode never enables both matrices or both curves
    a_ctl_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] |-> (!(ctl_reg[0].fwd && ctl_reg[0].inv)
                      && !(ctl_reg[0].dec_on && ctl_reg[0].enc_on)))
        else $error("conflicting unit enables");

    // A result held under stall stays valid in the next cycle
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[S_OUT] && !m_ready) |=> v_reg[S_OUT])
        else $error("stalled result dropped");
`endif

endmodule

>>> sim/srgb_linear_xyz_convert_checker.sv
// Checker for the sRGB / linear / XYZ converter: predicts each pixel and compares results.
`timescale 1ns / 1ps

module srgb_linear_xyz_convert_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [18:0] s_chan0_in,
    input  logic signed [18:0] s_chan1_in,
    input  logic signed [18:0] s_chan2_in,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [18:0] m_chan0_out,
    input  logic signed [18:0] m_chan1_out,
    input  logic signed [18:0] m_chan2_out,
    input  logic               m_saturated,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_data,
    output int                 errors,
    output int                 pending
);

    typedef logic [63:0] u64;

    typedef struct {
        logic signed [18:0] c0;
        logic signed [18:0] c1;
        logic signed [18:0] c2;
        logic               sat;
    } pixel_t;

    localparam longint CH_MAX   = 262143;
    localparam longint CH_MIN   = -262144;
    localparam longint LIN_CAP  = (64'sd1 <<< 35) - 1;
    localparam longint DEC_KNEE = 43432857;
    localparam longint ENC_KNEE = 3361671;
    localparam longint OFS      = 59055800;
    localparam longint GAIN     = 1132797624;
    localparam longint SLOPE    = 64'sd13872744366;
    localparam longint INVSLOPE = 83106952;
    localparam int     NPTS     = 1793;

    localparam longint RGB2XYZ [3][3] = '{
        '{6918924, 5999532, 3028287},
        '{3566836, 11999065, 1211315},
        '{323800, 1999844, 15946744}};
    localparam longint XYZ2RGB [3][3] = '{
        '{54368246, -25789936, -8365120},
        '{-16255445, 31470702, 696254},
        '{934491, -3422552, 17733517}};

    longint dec_curve [NPTS];
    longint enc_curve [NPTS];
    u64     sq_chain  [29];
    logic [2:0] cur_mode;
    pixel_t expected_px [$];
    int     n_in;
    int     n_out;

    assign pending = n_in - n_out;

    function automatic int top_bit(u64 v);
        int p;
        p = -1;
        for (int i = 0; i < 64; i++)
            if (v[i]) p = i;
        return p;
    endfunction

    function automatic u64 sqrt_floor(u64 v);
        u64 acc;
        u64 r;
        u64 b;
        acc = v;
        r   = 0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (acc >= r + b) begin
                acc = acc - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint div_floor(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    // log2 of a Q30 value in Q28, by repeated squaring of the mantissa
    function automatic longint log2_q28(u64 vin);
        u64     v;
        u64     m;
        int     p;
        longint fr;
        v  = (vin == 0) ? 64'd1 : vin;
        p  = top_bit(v);
        m  = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
        fr = 0;
        for (int i = 0; i < 28; i++) begin
            m  = (m * m + (64'd1 << 29)) >> 30;
            fr = fr <<< 1;
            if (m >= (64'd1 << 31)) begin
                m  = m >> 1;
                fr = fr | 1;
            end
        end
        return longint'(p - 30) * (64'sd1 <<< 28) + fr;
    endfunction

    // 2 to a Q28 power, Q30 result
    function automatic longint pow2_q30(longint l);
        longint n;
        longint f;
        u64     r;
        n = div_floor(l, 64'sd1 <<< 28);
        f = l - n * (64'sd1 <<< 28);
        r = 64'd1 << 30;
        for (int j = 1; j <= 28; j++)
            if (f[28-j]) r = (r * sq_chain[j] + (64'd1 << 29)) >> 30;
        if (n >= 0) begin
            if (n > 24) n = 24;
            return longint'(r << n);
        end
        if (-n >= 40) return 0;
        return longint'((r + (64'd1 << (-n - 1))) >> (-n));
    endfunction

    function automatic longint round_down(longint v, int s);
        u64 half;
        half = 64'd1 << (s - 1);
        if (v >= 0) return longint'((u64'(v) + half) >> s);
        return -longint'((u64'(-v) + half) >> s);
    endfunction

    // Interpolated lookup into one of the power-curve tables
    function automatic longint curve_lookup(bit enc, longint x);
        int     p;
        int     sh;
        int     idx;
        u64     t;
        u64     half;
        longint base;
        longint diff;
        p    = top_bit(u64'(x));
        sh   = p - 7;
        idx  = ((p - 21) << 7) + int'((x >> sh) & 127);
        t    = u64'(x) & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        base = enc ? enc_curve[idx] : dec_curve[idx];
        diff = (enc ? enc_curve[idx+1] : dec_curve[idx+1]) - base;
        if (diff >= 0) return base + longint'((u64'(diff) * t + half) >> sh);
        return base - longint'((u64'(-diff) * t + half) >> sh);
    endfunction

    // sRGB transfer in either direction, Q30 in and out
    function automatic longint transfer(bit enc, longint xin);
        longint x;
        x = xin;
        if (x < 0) x = 0;
        if (x > LIN_CAP) x = LIN_CAP;
        if (enc && x < ENC_KNEE)
            return longint'((u64'(x) * u64'(SLOPE) + (64'd1 << 29)) >> 30);
        if (!enc && x < DEC_KNEE)
            return longint'((u64'(x) * u64'(INVSLOPE) + (64'd1 << 29)) >> 30);
        return curve_lookup(enc, x);
    endfunction

    function automatic longint mat_row(bit inv, int r, longint a, longint b, longint c);
        if (inv)
            return round_down(XYZ2RGB[r][0] * a + XYZ2RGB[r][1] * b + XYZ2RGB[r][2] * c, 24);
        return round_down(RGB2XYZ[r][0] * a + RGB2XYZ[r][1] * b + RGB2XYZ[r][2] * c, 24);
    endfunction

    function automatic pixel_t convert_pixel(logic [2:0] md, logic signed [18:0] i0,
                                             logic signed [18:0] i1, logic signed [18:0] i2);
        pixel_t px;
        longint v [3];
        longint w [3];
        longint q;
        logic signed [18:0] o [3];
        v[0] = longint'(i0) <<< 14;
        v[1] = longint'(i1) <<< 14;
        v[2] = longint'(i2) <<< 14;
        if (md > slxc_pkg::MODE_XYZ2SRGB) begin
            px.c0 = i0; px.c1 = i1; px.c2 = i2; px.sat = 1'b0;
            return px;
        end
        case (md)
            slxc_pkg::MODE_SRGB2LIN:
                for (int i = 0; i < 3; i++) w[i] = transfer(1'b0, v[i]);
            slxc_pkg::MODE_LIN2SRGB:
                for (int i = 0; i < 3; i++) w[i] = transfer(1'b1, v[i]);
            slxc_pkg::MODE_LIN2XYZ, slxc_pkg::MODE_XYZ2LIN:
                for (int i = 0; i < 3; i++)
                    w[i] = mat_row(md == slxc_pkg::MODE_XYZ2LIN, i, v[0], v[1], v[2]);
            slxc_pkg::MODE_SRGB2XYZ: begin
                for (int i = 0; i < 3; i++) v[i] = transfer(1'b0, v[i]);
                for (int i = 0; i < 3; i++) w[i] = mat_row(1'b0, i, v[0], v[1], v[2]);
            end
            default: begin
                for (int i = 0; i < 3; i++) w[i] = mat_row(1'b1, i, v[0], v[1], v[2]);
                for (int i = 0; i < 3; i++) w[i] = transfer(1'b1, w[i]);
            end
        endcase
        px.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            q = round_down(w[i], 14);
            if (q > CH_MAX) begin q = CH_MAX; px.sat = 1'b1; end
            if (q < CH_MIN) begin q = CH_MIN; px.sat = 1'b1; end
            o[i] = q[18:0];
        end
        px.c0 = o[0]; px.c1 = o[1]; px.c2 = o[2];
        return px;
    endfunction

    // Curve tables sampled at the segment edges of 14 octaves
    initial begin
        longint g;
        u64     x;
        errors   = 0;
        n_in     = 0;
        n_out    = 0;
        cur_mode = slxc_pkg::MODE_SRGB2LIN;
        sq_chain[0] = 64'd1 << 31;
        sq_chain[1] = sqrt_floor(64'd1 << 61);
        for (int j = 2; j <= 28; j++) sq_chain[j] = sqrt_floor(sq_chain[j-1] << 30);
        g = log2_q28(u64'(GAIN));
        for (int i = 0; i < NPTS; i++) begin
            x = u64'(128 + (i & 127)) << (14 + (i >> 7));
            dec_curve[i] = pow2_q30(div_floor((log2_q28(x + u64'(OFS)) - g) * 12, 5));
            enc_curve[i] = pow2_q30(div_floor(log2_q28(x) * 5, 12) + g) - OFS;
        end
    end

    // Compare results first, then queue the prediction for a new pixel
    always @(posedge aclk) begin
        pixel_t e;
        if (!aresetn) begin
            cur_mode <= slxc_pkg::MODE_SRGB2LIN;
        end else begin
            if (m_valid && m_ready) begin
                n_out <= n_out + 1;
                if (expected_px.size() == 0) begin
                    $error("result item with no pixel outstanding");
                    errors <= errors + 1;
                end else begin
                    e = expected_px.pop_front();
                    if (m_chan0_out !== e.c0 || m_chan1_out !== e.c1 ||
                        m_chan2_out !== e.c2 || m_saturated !== e.sat) begin
                        errors <= errors + 1;
                        if (m_chan0_out !== e.c0)
                            $error("chan0_out: expected %0d, got %0d", e.c0, m_chan0_out);
                        if (m_chan1_out !== e.c1)
                            $error("chan1_out: expected %0d, got %0d", e.c1, m_chan1_out);
                        if (m_chan2_out !== e.c2)
                            $error("chan2_out: expected %0d, got %0d", e.c2, m_chan2_out);
                        if (m_saturated !== e.sat)
                            $error("saturated: expected %0d, got %0d", e.sat, m_saturated);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_px.push_back(convert_pixel(cur_mode, s_chan0_in, s_chan1_in,
                                                    s_chan2_in));
                n_in <= n_in + 1;
            end
            if (cfg_valid && cfg_ready) cur_mode <= cfg_data;
        end
    end

endmodule

>>> sim/tb_srgb_linear_xyz_convert.sv
// Testbench top for the sRGB / linear / XYZ converter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_srgb_linear_xyz_convert;

    localparam logic [2:0] MODE_PASS6 = 3'd6;
    localparam logic [2:0] MODE_PASS7 = 3'd7;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [18:0] s_chan0_in = '0;
    logic signed [18:0] s_chan1_in = '0;
    logic signed [18:0] s_chan2_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [18:0] m_chan0_out;
    logic signed [18:0] m_chan1_out;
    logic signed [18:0] m_chan2_out;
    logic               m_saturated;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_data = '0;
    int                 errors;
    int                 pending;
    bit                 hold_off_req = 1'b0;
    int                 burst_left = 1;

    always #5 aclk = ~aclk;

    srgb_linear_xyz_convert DUT (.*);

    srgb_linear_xyz_convert_checker u_checker (.*);

    // Receiver: ready stretches, random stalls, and one long hold on request
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (cyc % 250 < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Offer one pixel and hold it until taken; at the end of a burst pause for a random gap unless no_gaps
    task automatic put_pixel(logic signed [18:0] a, logic signed [18:0] b,
                             logic signed [18:0] c, bit no_gaps);
        int gap;
        s_valid    <= 1'b1;
        s_chan0_in <= a;
        s_chan1_in <= b;
        s_chan2_in <= c;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stop sending and let the pipe drain completely
    task automatic drain_pipe();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (25) @(posedge aclk);
    endtask

    task automatic write_mode(logic [2:0] md);
        cfg_valid <= 1'b1;
        cfg_data  <= md;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Channel values weighted toward the curve knees, unity and the extremes
    function automatic logic signed [18:0] pick_chan();
        case ($urandom_range(0, 6))
            0, 1: return 19'($urandom);
            2:    return 19'($urandom_range(0, 65536));
            3:    return 19'($urandom_range(0, 4096));
            4:    return $urandom_range(0, 1) ? 19'sh3ffff : -19'sh40000;
            5:    return 19'($urandom_range(0, 262143));
            default: return -19'($urandom_range(1, 70000));
        endcase
    endfunction

    initial begin
        int          knee [12];
        logic [2:0]  plan [11];
        knee = '{0, 1, -1, 262143, -262144, 2650, 2651, 205, 206,
                 65536, 16384, 196608};
        plan = '{slxc_pkg::MODE_LIN2SRGB, slxc_pkg::MODE_LIN2XYZ, slxc_pkg::MODE_XYZ2LIN,
                 slxc_pkg::MODE_SRGB2XYZ, slxc_pkg::MODE_XYZ2SRGB, MODE_PASS6, MODE_PASS7,
                 slxc_pkg::MODE_SRGB2LIN, slxc_pkg::MODE_XYZ2SRGB, slxc_pkg::MODE_SRGB2XYZ,
                 slxc_pkg::MODE_LIN2SRGB};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pixels: decode from reset, then encode
        for (int i = 0; i < 12; i++)
            put_pixel(19'(knee[i]), 19'(knee[(i+4)%12]), 19'(knee[(i+8)%12]), 1'b0);
        drain_pipe();
        write_mode(slxc_pkg::MODE_LIN2SRGB);
        for (int i = 0; i < 12; i++)
            put_pixel(19'(knee[(i+8)%12]), 19'(knee[i]), 19'(knee[(i+4)%12]), 1'b0);

        // Random phases, one conversion each
        for (int ph = 0; ph < 11; ph++) begin
            drain_pipe();
            write_mode(plan[ph]);
            if (ph == 3) hold_off_req = 1'b1;
            for (int n = 0; n < 60; n++) begin
                if (ph == 5 && n == 30) drain_pipe();
                put_pixel(pick_chan(), pick_chan(), pick_chan(), ph == 3);
            end
        end
        drain_pipe();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
